// ===== rtl/cdr_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cdr_pkg: shared types and constants for the charge duty regulator
// Register indexes, reset values, the register file and the regulator state.
// ---------------------------------------------------------------------------
package cdr_pkg;

  localparam int CFG_DATA_W  = 12;
  localparam int CFG_INDEX_W = 3;
  localparam int DUTY_W      = 6;
  localparam int WAIT_W      = 8;
  localparam int FULL_W      = 12;
  localparam int LEVEL_W     = 4;
  localparam int THRESH_W    = 12;

  // register indexes on the write port
  localparam logic [CFG_INDEX_W-1:0] REG_HIGH_THRESHOLD = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_LOW_THRESHOLD  = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_FIRST_WAIT     = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_LATER_WAIT     = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_DUTY_LIMIT     = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_FULL_TICKS     = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_FULL_LEVEL     = 3'd6;

  // register reset values
  localparam logic [THRESH_W-1:0] RST_HIGH_THRESHOLD = 12'd37;
  localparam logic [THRESH_W-1:0] RST_LOW_THRESHOLD  = 12'd36;
  localparam logic [WAIT_W-1:0]   RST_FIRST_WAIT     = 8'd20;
  localparam logic [WAIT_W-1:0]   RST_LATER_WAIT     = 8'd250;
  localparam logic [DUTY_W-1:0]   RST_DUTY_LIMIT     = 6'd35;
  localparam logic [FULL_W-1:0]   RST_FULL_TICKS     = 12'd2000;
  localparam logic [LEVEL_W-1:0]  RST_FULL_LEVEL     = 4'd8;

  typedef struct packed {
    logic [THRESH_W-1:0] high_threshold;
    logic [THRESH_W-1:0] low_threshold;
    logic [WAIT_W-1:0]   first_wait;
    logic [WAIT_W-1:0]   later_wait;
    logic [DUTY_W-1:0]   duty_limit;
    logic [FULL_W-1:0]   full_ticks;
    logic [LEVEL_W-1:0]  full_level;
  } cfg_t;

  typedef struct packed {
    logic [DUTY_W-1:0] duty;
    logic [WAIT_W-1:0] raise_count;
    logic [WAIT_W-1:0] lower_count;
    logic [WAIT_W-1:0] wait_limit;
    logic [FULL_W-1:0] full_count;
    logic              full_latched;
    logic              pwm_run;
  } state_t;

endpackage

// ===== rtl/cdr_if.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cdr_tick_if / cdr_result_if: valid/ready channels of the regulator
// One tick item in, one result item out per transfer.
// ---------------------------------------------------------------------------
interface cdr_tick_if #(
  parameter int SAMPLE_BITS = 12
);
  logic                   valid;
  logic                   ready;
  logic                   charger_present;
  logic [3:0]             battery_level;
  logic [SAMPLE_BITS-1:0] current_sample;
  logic                   regulate_window;

  modport source (output valid, charger_present, battery_level, current_sample,
                  regulate_window, input ready);
  modport sink   (input valid, charger_present, battery_level, current_sample,
                  regulate_window, output ready);
endinterface

interface cdr_result_if;
  logic       valid;
  logic       ready;
  logic [5:0] charge_duty;
  logic       charge_pwm_on;
  logic       charging;
  logic       charge_full;

  modport source (output valid, charge_duty, charge_pwm_on, charging, charge_full,
                  input ready);
  modport sink   (input valid, charge_duty, charge_pwm_on, charging, charge_full,
                  output ready);
endinterface

// ===== rtl/cdr_step.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cdr_step: next-state logic for one tick
// Full detection, threshold waits and clamped duty update.
// ---------------------------------------------------------------------------
module cdr_step import cdr_pkg::*; #(
  parameter int SAMPLE_BITS = 12
) (
  input  cfg_t                   cfg,
  input  state_t                 st,
  input  logic                   charger_present,
  input  logic [LEVEL_W-1:0]     battery_level,
  input  logic [SAMPLE_BITS-1:0] current_sample,
  input  logic                   regulate_window,
  output state_t                 st_next
);

  localparam int CMP_W = (SAMPLE_BITS > THRESH_W) ? SAMPLE_BITS : THRESH_W;

  logic [CMP_W-1:0]  sample_x;
  logic [CMP_W-1:0]  high_x;
  logic [CMP_W-1:0]  low_x;
  logic              above;
  logic              below;
  logic [FULL_W:0]   full_inc;
  logic [WAIT_W:0]   lower_inc;
  logic [WAIT_W:0]   raise_inc;
  logic [DUTY_W:0]   duty_work;

  // compares at full precision
  assign sample_x  = CMP_W'(current_sample);
  assign high_x    = CMP_W'(cfg.high_threshold);
  assign low_x     = CMP_W'(cfg.low_threshold);
  assign above     = sample_x > high_x;
  assign below     = sample_x < low_x;
  assign full_inc  = {1'b0, st.full_count} + 1'b1;
  assign lower_inc = {1'b0, st.lower_count} + 1'b1;
  assign raise_inc = {1'b0, st.raise_count} + 1'b1;

  always_comb begin
    st_next   = st;
    duty_work = {1'b0, st.duty};
    if (charger_present) begin
      if (battery_level >= cfg.full_level || st.full_latched) begin
        // full level: count ticks, then latch and stop the PWM
        if (full_inc >= {1'b0, cfg.full_ticks}) begin
          st_next.full_count   = cfg.full_ticks;
          st_next.full_latched = 1'b1;
          st_next.pwm_run      = 1'b0;
        end else begin
          st_next.full_count = full_inc[FULL_W-1:0];
        end
      end else begin
        st_next.full_count = '0;
        st_next.pwm_run    = 1'b1;
        if (regulate_window) begin
          if (above) begin
            // over current: lower after the wait, saturate at zero
            if (lower_inc > {1'b0, st.wait_limit}) begin
              if (st.duty != '0) begin
                duty_work = {1'b0, st.duty} - 1'b1;
              end
              st_next.lower_count = '0;
              st_next.wait_limit  = cfg.later_wait;
            end else begin
              st_next.lower_count = lower_inc[WAIT_W-1:0];
            end
            st_next.raise_count = '0;
          end else if (below) begin
            // under current: raise after the wait
            if (raise_inc > {1'b0, st.wait_limit}) begin
              duty_work           = {1'b0, st.duty} + 1'b1;
              st_next.raise_count = '0;
            end else begin
              st_next.raise_count = raise_inc[WAIT_W-1:0];
            end
            st_next.lower_count = '0;
          end else begin
            st_next.raise_count = '0;
            st_next.lower_count = '0;
          end
          // clamp to the duty limit
          if (duty_work > {1'b0, cfg.duty_limit}) begin
            st_next.duty = cfg.duty_limit;
          end else begin
            st_next.duty = duty_work[DUTY_W-1:0];
          end
        end
      end
    end else begin
      // unplugged: counters keep their values
      st_next.wait_limit   = cfg.first_wait;
      st_next.full_latched = 1'b0;
      st_next.duty         = '0;
      st_next.pwm_run      = 1'b0;
    end
  end

endmodule

// ===== rtl/charge_duty_regulator_unit.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// charge_duty_regulator_unit: charge PWM duty regulator, one item per tick
// Configuration registers, regulator state and the result register.
// ---------------------------------------------------------------------------
// Each accepted tick item updates the regulator state and produces one
// result item in the next cycle. An item is accepted in every cycle in
// which the result register is empty or its result is being taken, so the
// block sustains one item per clock; the only loop is the state update
// through cdr_step. Configuration writes take effect on the next
// accepted item and should be made while no result is pending.
module charge_duty_regulator_unit import cdr_pkg::*; #(
  parameter int SAMPLE_BITS = 12
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   wr_en,
  input  logic [CFG_INDEX_W-1:0] wr_index,
  input  logic [CFG_DATA_W-1:0]  wr_data,
  cdr_tick_if.sink               item,
  cdr_result_if.source           result
);

  cfg_t   cfg;
  state_t st;
  state_t st_next;
  logic   take;

  // accept whenever the result register is free or drains this cycle
  assign item.ready = !result.valid || result.ready;
  assign take       = item.valid && item.ready;

  // configuration register file
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.high_threshold <= RST_HIGH_THRESHOLD;
      cfg.low_threshold  <= RST_LOW_THRESHOLD;
      cfg.first_wait     <= RST_FIRST_WAIT;
      cfg.later_wait     <= RST_LATER_WAIT;
      cfg.duty_limit     <= RST_DUTY_LIMIT;
      cfg.full_ticks     <= RST_FULL_TICKS;
      cfg.full_level     <= RST_FULL_LEVEL;
    end else if (wr_en) begin
      case (wr_index)
        REG_HIGH_THRESHOLD: cfg.high_threshold <= wr_data[THRESH_W-1:0];
        REG_LOW_THRESHOLD:  cfg.low_threshold  <= wr_data[THRESH_W-1:0];
        REG_FIRST_WAIT:     cfg.first_wait     <= wr_data[WAIT_W-1:0];
        REG_LATER_WAIT:     cfg.later_wait     <= wr_data[WAIT_W-1:0];
        REG_DUTY_LIMIT:     cfg.duty_limit     <= wr_data[DUTY_W-1:0];
        REG_FULL_TICKS:     cfg.full_ticks     <= wr_data[FULL_W-1:0];
        REG_FULL_LEVEL:     cfg.full_level     <= wr_data[LEVEL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  cdr_step #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_step (
    .cfg             (cfg),
    .st              (st),
    .charger_present (item.charger_present),
    .battery_level   (item.battery_level),
    .current_sample  (item.current_sample),
    .regulate_window (item.regulate_window),
    .st_next         (st_next)
  );

  // regulator state, updated on each input transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      st.duty         <= '0;
      st.raise_count  <= '0;
      st.lower_count  <= '0;
      st.wait_limit   <= RST_FIRST_WAIT;
      st.full_count   <= '0;
      st.full_latched <= 1'b0;
      st.pwm_run      <= 1'b0;
    end else if (take) begin
      st <= st_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (take) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      result.charge_duty   <= st_next.duty;
      result.charge_pwm_on <= st_next.pwm_run;
      result.charging      <= item.charger_present;
      result.charge_full   <= st_next.full_latched;
    end
  end

  // an accepted tick always leaves a result behind
  a_take_result: assert property (@(posedge clk) disable iff (rst)
    take |=> result.valid)
    else $error("accepted tick produced no result");

  // unplugged tick clears duty, PWM and full flag
  a_unplug_clear: assert property (@(posedge clk) disable iff (rst)
    take && !item.charger_present |=>
      result.charge_duty == '0 && !result.charge_pwm_on && !result.charge_full)
    else $error("unplugged tick did not clear the regulator");

  // a latched full charge never runs the PWM
  a_full_pwm_off: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.charge_full |-> !result.charge_pwm_on)
    else $error("PWM running after full charge latched");

  // the full latch holds while the charger stays present
  a_full_hold: assert property (@(posedge clk) disable iff (rst)
    take && st.full_latched && item.charger_present |=> result.charge_full)
    else $error("full latch dropped while charger present");

endmodule
